@@ rtl/core/isf_pkg.sv @@
// Package for the incremental subsequence filter.
// Holds sizes, operation codes and the command type passed from front to back.
// No dependencies.
package isf_pkg;

    localparam int NWORDS   = 64;
    localparam int MAXLEN   = 256;
    localparam int MAXQUERY = 256;

    localparam int WIDX_W  = 6;
    localparam int POS_W   = 8;
    localparam int LET_W   = 5;
    localparam int OP_W    = 2;
    localparam int CNT_W   = 7;
    localparam int LEN_W   = 9;
    localparam int DEPTH_W = 9;

    localparam logic [LEN_W-1:0]   FAIL_POS  = LEN_W'(MAXLEN);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAXQUERY);
    localparam logic [CNT_W-1:0]   WORDS_MAX = CNT_W'(NWORDS);

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_TYPE = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TYPE = 2'd1,
        CMD_DEL  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [WIDX_W-1:0]  widx;
        logic [POS_W-1:0]   pos;
        logic [LET_W-1:0]   letter;
    } cmd_t;

endpackage

@@ rtl/core/incremental_subsequence_filter.sv @@
// Top level of the incremental subsequence filter.
// Depends on isf_pkg, isf_front and isf_back.
//
// A load transaction writes its letter in the back end and gives no result. A type
// transaction is issued, then walks all 64 words one at a time: per word it reads
// the stack and length, starts the scan and writes the new position, with a read
// state and a compare state per letter compared and one more check when the scan
// runs past the word's end, then loads the result register. Each compare waits on
// the letter read registered in the read state before it. A delete that leaves at
// least one letter, or a type on a full query, recounts the match stack with a read
// and an accumulate state per word; a delete that leaves the query empty goes
// straight to the result. The result step stalls while an earlier result waits
// unpopped. A two-entry command queue sits in front, and one result register at
// the output.
module incremental_subsequence_filter
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [isf_pkg::OP_W-1:0]    operation,
    input  logic [isf_pkg::WIDX_W-1:0]  word_index,
    input  logic [isf_pkg::POS_W-1:0]   char_position,
    input  logic [isf_pkg::LET_W-1:0]   letter,
    output logic                        empty,
    input  logic                        pop,
    output logic [isf_pkg::CNT_W-1:0]   match_count,
    input  logic                        word_count_we,
    input  logic [isf_pkg::CNT_W-1:0]   word_count
);

    logic          cmd_valid;
    logic          cmd_pop;
    isf_pkg::cmd_t cmd;

    isf_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .word_index    (word_index),
        .char_position (char_position),
        .letter        (letter),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    isf_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_count_we (word_count_we),
        .word_count    (word_count),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .empty         (empty),
        .pop           (pop),
        .match_count   (match_count)
    );

endmodule

@@ rtl/core/isf_front.sv @@
// Front end: accepts input transactions, drops unused codes, queues commands.
// Depends on isf_pkg.
module isf_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [isf_pkg::OP_W-1:0]    operation,
    input  logic [isf_pkg::WIDX_W-1:0]  word_index,
    input  logic [isf_pkg::POS_W-1:0]   char_position,
    input  logic [isf_pkg::LET_W-1:0]   letter,
    output logic                        cmd_valid,
    output isf_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);

    isf_pkg::cmd_t q_reg [2];
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          enq;
    isf_pkg::cmd_t new_cmd;

    always_comb
    begin
        new_cmd.widx   = word_index;
        new_cmd.pos    = char_position;
        new_cmd.letter = letter;
        case (operation)
            isf_pkg::OP_LOAD: new_cmd.kind = isf_pkg::CMD_LOAD;
            isf_pkg::OP_TYPE: new_cmd.kind = isf_pkg::CMD_TYPE;
            default:          new_cmd.kind = isf_pkg::CMD_DEL;
        endcase
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign enq       = push && !full &&
                       (operation inside {isf_pkg::OP_LOAD, isf_pkg::OP_TYPE, isf_pkg::OP_DEL});

    always_comb
    begin
        wr_next  = wr_reg ^ enq;
        rd_next  = rd_reg ^ (cmd_pop && cmd_valid);
        cnt_next = cnt_reg + {1'b0, enq} - {1'b0, cmd_pop && cmd_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_reg] <= new_cmd;
        end
    end

endmodule

@@ rtl/core/isf_back.sv @@
// Back end: dictionary and match-stack memories, scan sequencer, result register.
// Depends on isf_pkg.
module isf_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        word_count_we,
    input  logic [isf_pkg::CNT_W-1:0]   word_count,
    input  logic                        cmd_valid,
    input  isf_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [isf_pkg::CNT_W-1:0]   match_count
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_TRD    = 9'b000000010,
        S_TSTART = 9'b000000100,
        S_TLRD   = 9'b000001000,
        S_TLCHK  = 9'b000010000,
        S_TWR    = 9'b000100000,
        S_CRD    = 9'b001000000,
        S_CACC   = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    localparam int AW = isf_pkg::WIDX_W + isf_pkg::POS_W;

    logic [isf_pkg::LET_W-1:0] let_mem [isf_pkg::NWORDS*isf_pkg::MAXLEN];
    logic [isf_pkg::LEN_W-1:0] stk_mem [isf_pkg::NWORDS*isf_pkg::MAXQUERY];
    logic [isf_pkg::LEN_W-1:0] len_mem [isf_pkg::NWORDS];
    logic [isf_pkg::NWORDS-1:0] len_vld_reg;

    logic [isf_pkg::LET_W-1:0] let_q;
    logic [isf_pkg::LEN_W-1:0] stk_q;
    logic [isf_pkg::LEN_W-1:0] len_q;
    logic                      vld_q;

    state_t                       state_reg, state_next;
    logic [isf_pkg::CNT_W-1:0]    wc_reg;
    logic [isf_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic [isf_pkg::WIDX_W-1:0]   w_reg, w_next;
    logic [isf_pkg::LEN_W-1:0]    p_reg, p_next;
    logic [isf_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [isf_pkg::LEN_W-1:0]    res_reg, res_next;
    logic [isf_pkg::LET_W-1:0]    letter_reg, letter_next;
    logic [isf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         out_vld_reg, out_vld_next;
    logic [isf_pkg::CNT_W-1:0]    out_reg, out_next;

    logic [isf_pkg::CNT_W-1:0]    used;
    logic [isf_pkg::DEPTH_W-1:0]  depth_m1;
    logic                         w_used;
    logic                         w_last;
    logic                         load_we;
    logic                         stk_we;

    assign used     = (wc_reg > isf_pkg::WORDS_MAX) ? isf_pkg::WORDS_MAX : wc_reg;
    assign depth_m1 = depth_reg - 1'b1;
    assign w_used   = ({1'b0, w_reg} < used);
    assign w_last   = (w_reg == isf_pkg::WIDX_W'(isf_pkg::NWORDS - 1));
    assign load_we  = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == isf_pkg::CMD_LOAD);
    assign stk_we   = (state_reg == S_TWR);
    assign cmd_pop  = (state_reg == S_IDLE);
    assign empty       = !out_vld_reg;
    assign match_count = out_reg;

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            let_mem[{cmd.widx, cmd.pos}] <= cmd.letter;
        end
        let_q <= let_mem[{w_reg, p_reg[isf_pkg::POS_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[{w_reg, depth_reg[AW-isf_pkg::WIDX_W-1:0]}] <= res_reg;
        end
        stk_q <= stk_mem[{w_reg, depth_m1[AW-isf_pkg::WIDX_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            len_mem[cmd.widx] <= {1'b0, cmd.pos} + 1'b1;
        end
        len_q <= len_mem[w_reg];
        vld_q <= len_vld_reg[w_reg];
    end

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        w_next       = w_reg;
        p_next       = p_reg;
        len_next     = len_reg;
        res_next     = res_reg;
        letter_next  = letter_reg;
        cnt_next     = cnt_reg;
        out_vld_next = out_vld_reg && !pop;
        out_next     = out_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    w_next      = '0;
                    cnt_next    = '0;
                    letter_next = cmd.letter;
                    case (cmd.kind)
                        isf_pkg::CMD_TYPE:
                        begin
                            if (depth_reg == isf_pkg::DEPTH_MAX)
                                state_next = S_CRD;
                            else
                                state_next = S_TRD;
                        end
                        isf_pkg::CMD_DEL:
                        begin
                            if (depth_reg <= isf_pkg::DEPTH_W'(1))
                            begin
                                depth_next = '0;
                                cnt_next   = used;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                depth_next = depth_m1;
                                state_next = S_CRD;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_TRD: state_next = S_TSTART;
            S_TSTART:
            begin
                len_next = vld_q ? len_q : '0;
                if (depth_reg != '0 && stk_q[isf_pkg::LEN_W-1])
                begin
                    res_next   = isf_pkg::FAIL_POS;
                    state_next = S_TWR;
                end
                else
                begin
                    p_next     = (depth_reg == '0) ? '0 : stk_q + 1'b1;
                    state_next = S_TLRD;
                end
            end
            S_TLRD:
            begin
                if (p_reg >= len_reg)
                begin
                    res_next   = isf_pkg::FAIL_POS;
                    state_next = S_TWR;
                end
                else
                    state_next = S_TLCHK;
            end
            S_TLCHK:
            begin
                if (let_q == letter_reg)
                begin
                    res_next   = p_reg;
                    state_next = S_TWR;
                end
                else
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_TLRD;
                end
            end
            S_TWR:
            begin
                if (w_used && res_reg != isf_pkg::FAIL_POS)
                    cnt_next = cnt_reg + 1'b1;
                if (w_last)
                begin
                    depth_next = depth_reg + 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_TRD;
                end
            end
            S_CRD: state_next = S_CACC;
            S_CACC:
            begin
                if (w_used && stk_q != isf_pkg::FAIL_POS)
                    cnt_next = cnt_reg + 1'b1;
                if (w_last)
                    state_next = S_OUT;
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_OUT:
            begin
                if (!out_vld_reg || pop)
                begin
                    out_vld_next = 1'b1;
                    out_next     = cnt_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            wc_reg      <= isf_pkg::CNT_W'(1);
            out_vld_reg <= 1'b0;
            len_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            out_vld_reg <= out_vld_next;
            if (word_count_we)
                wc_reg <= word_count;
            if (load_we)
                len_vld_reg[cmd.widx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg      <= w_next;
        p_reg      <= p_next;
        len_reg    <= len_next;
        res_reg    <= res_next;
        letter_reg <= letter_next;
        cnt_reg    <= cnt_next;
        out_reg    <= out_next;
    end

endmodule

@@ rtl/core/isf_checker.sv @@
// Port-level checker for the incremental subsequence filter, with its bind.
// Depends on isf_pkg and incremental_subsequence_filter.
module isf_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      empty,
    input logic                      pop,
    input logic [isf_pkg::CNT_W-1:0] match_count
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result transaction dropped before pop");

    a_stable_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(match_count))
        else $error("waiting result changed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> match_count <= isf_pkg::WORDS_MAX)
        else $error("match count above word limit");

    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> empty)
        else $error("result present right after reset");

endmodule

bind incremental_subsequence_filter isf_checker u_isf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .match_count (match_count)
);

@@ tb/sv/tb_incremental_subsequence_filter.sv @@
// Testbench for incremental_subsequence_filter: a queue-fed driver, a monitor and a scoreboard.
// An internal dictionary/query model predicts every match count.
// Depends on isf_pkg and the RTL top level.
module tb_incremental_subsequence_filter;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [isf_pkg::OP_W-1:0]   op;
        logic [isf_pkg::WIDX_W-1:0] widx;
        logic [isf_pkg::POS_W-1:0]  pos;
        logic [isf_pkg::LET_W-1:0]  let_code;
    } isf_cmd_t;

    localparam int IDLE_LIMIT = 200000;
    localparam logic [isf_pkg::OP_W-1:0] OP_NONE = 2'd3;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic [isf_pkg::OP_W-1:0]    operation;
    logic [isf_pkg::WIDX_W-1:0]  word_index;
    logic [isf_pkg::POS_W-1:0]   char_position;
    logic [isf_pkg::LET_W-1:0]   letter;
    logic                        empty;
    logic                        pop;
    logic [isf_pkg::CNT_W-1:0]   match_count;
    logic                        word_count_we;
    logic [isf_pkg::CNT_W-1:0]   word_count;

    isf_cmd_t                  cmd_q[$];
    logic [isf_pkg::CNT_W-1:0] count_q[$];

    logic [isf_pkg::LET_W-1:0] dict_letters [isf_pkg::NWORDS][isf_pkg::MAXLEN];
    int                        dict_len     [isf_pkg::NWORDS];
    int                        pos_stack    [isf_pkg::NWORDS][isf_pkg::MAXQUERY];
    int                        qdepth;
    int                        words_used;
    int                        gen_fill     [isf_pkg::NWORDS];

    int  errors;
    int  idle_cycles;
    int  send_gap;
    int  recv_gap;
    int  hold_left;
    bit  hold_go;
    bit  sender_hold;
    bit  take_gap;

    incremental_subsequence_filter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .word_index    (word_index),
        .char_position (char_position),
        .letter        (letter),
        .empty         (empty),
        .pop           (pop),
        .match_count   (match_count),
        .word_count_we (word_count_we),
        .word_count    (word_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int next_match(int w, logic [isf_pkg::LET_W-1:0] l);
        int start;
        int p;
        if (qdepth == 0)
            start = 0;
        else
        begin
            if (pos_stack[w][qdepth-1] >= isf_pkg::MAXLEN)
                return isf_pkg::MAXLEN;
            start = pos_stack[w][qdepth-1] + 1;
        end
        for (p = start; p < dict_len[w]; p++)
            if (dict_letters[w][p] == l)
                return p;
        return isf_pkg::MAXLEN;
    endfunction

    function automatic logic [isf_pkg::CNT_W-1:0] live_words();
        int n;
        if (qdepth == 0)
            return isf_pkg::CNT_W'(words_used);
        n = 0;
        for (int w = 0; w < words_used; w++)
            if (pos_stack[w][qdepth-1] != isf_pkg::MAXLEN)
                n++;
        return isf_pkg::CNT_W'(n);
    endfunction

    task automatic apply_cmd(isf_cmd_t c);
        case (c.op)
            isf_pkg::OP_LOAD:
            begin
                dict_letters[c.widx][c.pos] = c.let_code;
                dict_len[c.widx] = int'(c.pos) + 1;
            end
            isf_pkg::OP_TYPE:
            begin
                if (qdepth < isf_pkg::MAXQUERY)
                begin
                    for (int w = 0; w < isf_pkg::NWORDS; w++)
                        pos_stack[w][qdepth] = next_match(w, c.let_code);
                    qdepth++;
                end
                count_q = {count_q, live_words()};
            end
            isf_pkg::OP_DEL:
            begin
                if (qdepth > 0)
                    qdepth--;
                count_q = {count_q, live_words()};
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Driver
    always @(negedge clk)
    begin
        if (take_gap)
        begin
            take_gap = 1'b0;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: send_gap = 0;
                6, 7, 8:          send_gap = $urandom_range(3, 1);
                default:          send_gap = $urandom_range(40, 10);
            endcase
        end
        if (send_gap > 0)
        begin
            send_gap--;
            push <= 1'b0;
        end
        else if (cmd_q.size() > 0 && !sender_hold && rst_n)
        begin
            push          <= 1'b1;
            operation     <= cmd_q[0].op;
            word_index    <= cmd_q[0].widx;
            char_position <= cmd_q[0].pos;
            letter        <= cmd_q[0].let_code;
        end
        else
            push <= 1'b0;
    end

    // Receiver
    always @(negedge clk)
    begin
        if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_left = 3000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: recv_gap = 0;
                6, 7, 8:          recv_gap = $urandom_range(3, 1);
                default:          recv_gap = $urandom_range(40, 10);
            endcase
        end
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        idle_cycles++;
        if (push && !full)
        begin
            apply_cmd(cmd_q.pop_front());
            take_gap    = 1'b1;
            idle_cycles = 0;
        end
        if (pop && !empty)
        begin
            idle_cycles = 0;
            if (count_q.size() == 0)
                report("unexpected match_count", int'(match_count), -1);
            else if (match_count !== count_q[0])
                report("match_count", int'(match_count), int'(count_q.pop_front()));
            else
                void'(count_q.pop_front());
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send(logic [isf_pkg::OP_W-1:0] op, int w, int p, int l);
        isf_cmd_t c;
        c.op       = op;
        c.widx     = isf_pkg::WIDX_W'(w);
        c.pos      = isf_pkg::POS_W'(p);
        c.let_code = isf_pkg::LET_W'(l);
        if (op == isf_pkg::OP_LOAD && p == gen_fill[w])
            gen_fill[w]++;
        cmd_q = {cmd_q, c};
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || push || count_q.size() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic set_words(int n);
        drain();
        @(negedge clk);
        word_count_we <= 1'b1;
        word_count    <= isf_pkg::CNT_W'(n);
        @(posedge clk);
        words_used = (n > isf_pkg::NWORDS) ? isf_pkg::NWORDS : n;
        @(negedge clk);
        word_count_we <= 1'b0;
    endtask

    task automatic send_load(int w, int maxlen);
        int top;
        top = (gen_fill[w] < maxlen) ? gen_fill[w] : maxlen;
        if (top > isf_pkg::MAXLEN - 1)
            top = isf_pkg::MAXLEN - 1;
        send(isf_pkg::OP_LOAD, w, $urandom_range(top), $urandom_range(9) == 0 ?
             $urandom_range(31) : $urandom_range(3));
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7:
                    send_load($urandom_range(isf_pkg::NWORDS - 1), 11);
                8, 9, 10, 11, 12, 13, 14:
                    send(isf_pkg::OP_TYPE, $urandom_range(63), $urandom_range(255),
                         $urandom_range(7) == 0 ? $urandom_range(31) : $urandom_range(3));
                15, 16, 17, 18:
                    send(isf_pkg::OP_DEL, $urandom_range(63), $urandom_range(255),
                         $urandom_range(31));
                default:
                    send(OP_NONE, $urandom_range(63), $urandom_range(255), $urandom_range(31));
            endcase
        end
    endtask

    initial
    begin
        errors = 0; idle_cycles = 0; send_gap = 0; recv_gap = 0; hold_left = 0;
        hold_go = 0; sender_hold = 0; take_gap = 0;
        qdepth = 0; words_used = 1;
        for (int w = 0; w < isf_pkg::NWORDS; w++)
        begin
            dict_len[w] = 0;
            gen_fill[w] = 0;
        end
        rst_n = 1'b0; push = 1'b0; pop = 1'b0;
        operation = isf_pkg::OP_LOAD; word_index = '0; char_position = '0; letter = '0;
        word_count_we = 1'b0; word_count = isf_pkg::CNT_W'(1);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty query, empty dictionary, raw letter codes, unused code
        send(isf_pkg::OP_DEL, 0, 0, 0);
        send(isf_pkg::OP_TYPE, 0, 0, 0);
        send(isf_pkg::OP_DEL, 63, 255, 31);
        send(isf_pkg::OP_LOAD, 0, 0, 0);
        send(isf_pkg::OP_LOAD, 0, 1, 31);
        send(isf_pkg::OP_TYPE, 0, 0, 0);
        send(isf_pkg::OP_TYPE, 0, 0, 31);
        send(isf_pkg::OP_TYPE, 0, 0, 31);
        send(OP_NONE, 63, 255, 31);
        send(isf_pkg::OP_DEL, 0, 0, 0);
        send(isf_pkg::OP_DEL, 0, 0, 0);
        send(isf_pkg::OP_DEL, 0, 0, 0);
        send(isf_pkg::OP_DEL, 0, 0, 0);
        send(isf_pkg::OP_LOAD, 63, 0, 25);
        set_words(0);
        send(isf_pkg::OP_TYPE, 0, 0, 25);
        send(isf_pkg::OP_DEL, 0, 0, 0);
        set_words(127);
        send(isf_pkg::OP_TYPE, 0, 0, 25);
        send(isf_pkg::OP_TYPE, 0, 0, 0);
        send(isf_pkg::OP_DEL, 0, 0, 0);
        send(isf_pkg::OP_DEL, 0, 0, 0);

        // one longer word and a set of short ones
        for (int p = 0; p < 16; p++)
            send(isf_pkg::OP_LOAD, 62, p, $urandom_range(31));
        for (int w = 1; w < 7; w++)
            for (int p = 0; p < 3; p++)
                send(isf_pkg::OP_LOAD, w, p, $urandom_range(3));
        set_words(64);

        send_random(15);
        hold_go = 1'b1;
        send_random(10);
        drain();
        sender_hold = 1'b1;
        repeat (50) @(posedge clk);
        sender_hold = 1'b0;
        set_words(37);
        send_random(15);
        set_words(1);
        send_random(10);

        drain();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
